[rtl/spf_pkg.sv]
package spf_pkg;

	// coordinate and fraction format
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// derived widths
	localparam int DIFF_W = COORD_WIDTH + 1;          // exact difference
	localparam int SQ_W   = 2 * DIFF_W;               // one square
	localparam int LEN_W  = COORD_WIDTH + 2;          // root width
	localparam int RAD_W  = 2 * LEN_W;                // sum of three squares
	localparam int REM_W  = LEN_W + 3;                // root remainder
	localparam int QUO_W  = FRAC_BITS + 1;            // unit component, up to 1.0
	localparam int NUM_W  = DIFF_W + FRAC_BITS;       // divider numerator
	localparam int DIV_W  = LEN_W + QUO_W;            // divider compare width
	localparam int PROD_W = COORD_WIDTH + LEN_W;      // k times stretch
	localparam int HI_W   = PROD_W - FRAC_BITS;
	localparam int FMAG_W = COORD_WIDTH + FRAC_BITS;  // clipped force magnitude
	localparam int MAG_W  = FMAG_W + QUO_W;           // force times unit
	localparam int SPAN_W = COORD_WIDTH + 3;

	localparam logic [FMAG_W-1:0] F_CLIP = FMAG_W'(1) << (COORD_WIDTH - 1 + FRAC_BITS);

	localparam logic signed [COORD_WIDTH-1:0] FORCE_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] FORCE_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// per-item data that travels beside the root pipeline
	typedef struct packed {
		logic [2:0]                   dneg;
		logic [2:0][DIFF_W-1:0]       dmag;
		logic [COORD_WIDTH-1:0]       rest;
		logic [COORD_WIDTH-1:0]       k;
	} root_side_t;

	// per-item data that travels beside the divider pipeline
	typedef struct packed {
		logic [FMAG_W-1:0] fmag;
		logic              fneg;
		logic [2:0]        dneg;
		logic [LEN_W-1:0]  len;
		logic              degen;
	} div_side_t;

endpackage

[rtl/spf_sqrt.sv]
module spf_sqrt (
	input  logic                      clk,
	input  logic [spf_pkg::RAD_W-1:0] rad,
	output logic [spf_pkg::LEN_W-1:0] root
);
	import spf_pkg::*;

	logic [RAD_W-1:0] rad_s  [0:LEN_W-1];
	logic [REM_W-1:0] rem_s  [0:LEN_W-1];
	logic [LEN_W-1:0] root_s [0:LEN_W-1];

	logic [RAD_W-1:0] rad_n  [0:LEN_W-1];
	logic [REM_W-1:0] rem_n  [0:LEN_W-1];
	logic [LEN_W-1:0] root_n [0:LEN_W-1];

	// one root bit per stage, two radicand bits brought down each step
	always_comb begin
		logic [RAD_W-1:0] rad_c;
		logic [REM_W-1:0] rem_c;
		logic [LEN_W-1:0] root_c;
		logic [REM_W-1:0] acc;
		logic [REM_W-1:0] trial;
		for (int k = 0; k < LEN_W; k++) begin
			if (k == 0) begin
				rad_c  = rad;
				rem_c  = '0;
				root_c = '0;
			end else begin
				rad_c  = rad_s[k-1];
				rem_c  = rem_s[k-1];
				root_c = root_s[k-1];
			end
			acc      = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
			trial    = {1'b0, root_c, 2'b01};
			rad_n[k] = {rad_c[RAD_W-3:0], 2'b00};
			if (acc >= trial) begin
				rem_n[k]  = acc - trial;
				root_n[k] = {root_c[LEN_W-2:0], 1'b1};
			end else begin
				rem_n[k]  = acc;
				root_n[k] = {root_c[LEN_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < LEN_W; k++) begin
			rad_s[k]  <= rad_n[k];
			rem_s[k]  <= rem_n[k];
			root_s[k] <= root_n[k];
		end
	end

	assign root = root_s[LEN_W-1];

endmodule

[rtl/spf_div.sv]
module spf_div (
	input  logic                      clk,
	input  logic [spf_pkg::NUM_W-1:0] num,
	input  logic [spf_pkg::LEN_W-1:0] den,
	output logic [spf_pkg::QUO_W-1:0] quo
);
	import spf_pkg::*;

	logic [DIV_W-1:0] rem_s [0:QUO_W-1];
	logic [LEN_W-1:0] den_s [0:QUO_W-1];
	logic [QUO_W-1:0] quo_s [0:QUO_W-1];

	logic [DIV_W-1:0] rem_n [0:QUO_W-1];
	logic [QUO_W-1:0] quo_n [0:QUO_W-1];

	// restoring division, one quotient bit per stage, msb first
	always_comb begin
		logic [DIV_W-1:0] rem_c;
		logic [LEN_W-1:0] den_c;
		logic [QUO_W-1:0] quo_c;
		logic [DIV_W-1:0] dsh;
		for (int k = 0; k < QUO_W; k++) begin
			if (k == 0) begin
				rem_c = DIV_W'(num);
				den_c = den;
				quo_c = '0;
			end else begin
				rem_c = rem_s[k-1];
				den_c = den_s[k-1];
				quo_c = quo_s[k-1];
			end
			dsh = DIV_W'(den_c) << (QUO_W - 1 - k);
			if (rem_c >= dsh) begin
				rem_n[k] = rem_c - dsh;
				quo_n[k] = {quo_c[QUO_W-2:0], 1'b1};
			end else begin
				rem_n[k] = rem_c;
				quo_n[k] = {quo_c[QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		den_s[0] <= den;
		for (int k = 0; k < QUO_W; k++) begin
			rem_s[k] <= rem_n[k];
			quo_s[k] <= quo_n[k];
		end
		for (int k = 1; k < QUO_W; k++) begin
			den_s[k] <= den_s[k-1];
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

[rtl/spring_pair_force_core.sv]
// Hooke spring force between two points in 3D, Q16.16 fixed point.
// Input channel: raise start with both endpoint positions, the rest length
// and the stiffness; the item is taken at any clock edge where start is high
// and busy is low. busy stays low: a new item may enter every cycle.
// Result channel: done is high for one cycle with the forces on A and B, the
// span length and the degenerate flag; the receiver takes it in that cycle
// and cannot hold it off, so nothing in the pipeline ever stalls.
// The length comes from a square root pipeline with one root bit per
// stage (LEN_W stages); the three unit components from three divider pipelines
// with one quotient bit per stage (QUO_W stages). Throughput is one item per
// cycle.
// Coincident points give zero forces, zero span and degenerate high.
// Forces saturate to 32 bits; the force on B is the saturated negation of A's.
// Reset clears all valid bits, so no result appears until new items arrive.
module spring_pair_force_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [spf_pkg::COORD_WIDTH-1:0] point_a_x,
	input  logic signed [spf_pkg::COORD_WIDTH-1:0] point_a_y,
	input  logic signed [spf_pkg::COORD_WIDTH-1:0] point_a_z,
	input  logic signed [spf_pkg::COORD_WIDTH-1:0] point_b_x,
	input  logic signed [spf_pkg::COORD_WIDTH-1:0] point_b_y,
	input  logic signed [spf_pkg::COORD_WIDTH-1:0] point_b_z,
	input  logic        [spf_pkg::COORD_WIDTH-1:0] rest_len,
	input  logic        [spf_pkg::COORD_WIDTH-1:0] stiffness,
	output logic                                   done,
	output logic signed [spf_pkg::COORD_WIDTH-1:0] force_a_x,
	output logic signed [spf_pkg::COORD_WIDTH-1:0] force_a_y,
	output logic signed [spf_pkg::COORD_WIDTH-1:0] force_a_z,
	output logic signed [spf_pkg::COORD_WIDTH-1:0] force_b_x,
	output logic signed [spf_pkg::COORD_WIDTH-1:0] force_b_y,
	output logic signed [spf_pkg::COORD_WIDTH-1:0] force_b_z,
	output logic        [spf_pkg::SPAN_W-1:0]      span_length,
	output logic                                   degenerate
);
	import spf_pkg::*;

	localparam int DLY_N = QUO_W - 2;

	assign busy = 1'b0;

	// stage 1: differences and magnitudes
	logic [2:0][COORD_WIDTH-1:0] pa;
	logic [2:0][COORD_WIDTH-1:0] pb;
	logic [2:0][DIFF_W-1:0]      d_c;

	assign pa = {point_a_z, point_a_y, point_a_x};
	assign pb = {point_b_z, point_b_y, point_b_x};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = {pb[i][COORD_WIDTH-1], pb[i]} - {pa[i][COORD_WIDTH-1], pa[i]};
		end
	end

	logic                   vld_s1;
	root_side_t             side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			side_s1.dneg[i] <= d_c[i][DIFF_W-1];
			side_s1.dmag[i] <= d_c[i][DIFF_W-1] ? (DIFF_W'(0) - d_c[i]) : d_c[i];
		end
		side_s1.rest <= rest_len;
		side_s1.k    <= stiffness;
	end

	// stage 2: squares
	logic                    vld_s2;
	root_side_t              side_s2;
	logic [2:0][SQ_W-1:0]    sq_s2;

	// stage 3: sum of squares
	logic                    vld_s3;
	root_side_t              side_s3;
	logic [RAD_W-1:0]        sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= side_s1.dmag[i] * side_s1.dmag[i];
		end
		side_s2 <= side_s1;
		sum_s3  <= RAD_W'(sq_s2[0]) + RAD_W'(sq_s2[1]) + RAD_W'(sq_s2[2]);
		side_s3 <= side_s2;
	end

	// square root pipeline with side data alongside
	logic [LEN_W-1:0] len_c;
	logic             vld_r [0:LEN_W-1];
	root_side_t       side_r [0:LEN_W-1];

	spf_sqrt u_sqrt (
		.clk  (clk),
		.rad  (sum_s3),
		.root (len_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < LEN_W; n++) begin
				vld_r[n] <= 1'b0;
			end
		end else begin
			vld_r[0] <= vld_s3;
			for (int n = 1; n < LEN_W; n++) begin
				vld_r[n] <= vld_r[n-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_r[0] <= side_s3;
		for (int n = 1; n < LEN_W; n++) begin
			side_r[n] <= side_r[n-1];
		end
	end

	// stretch against rest length, divider operands
	logic [LEN_W:0] stretch_c;
	assign stretch_c = {1'b0, len_c} - (LEN_W + 1)'(side_r[LEN_W-1].rest);

	logic                   vld_f1;
	logic [LEN_W-1:0]       len_f1;
	logic [LEN_W-1:0]       smag_f1;
	logic                   fneg_f1;
	logic [2:0]             dneg_f1;
	logic [COORD_WIDTH-1:0] k_f1;
	logic                   degen_f1;
	logic [2:0][NUM_W-1:0]  num_f1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1 <= 1'b0;
		end else begin
			vld_f1 <= vld_r[LEN_W-1];
		end
	end

	always_ff @(posedge clk) begin
		len_f1   <= len_c;
		fneg_f1  <= stretch_c[LEN_W];
		smag_f1  <= stretch_c[LEN_W] ? LEN_W'((LEN_W + 1)'(0) - stretch_c)
		                             : stretch_c[LEN_W-1:0];
		dneg_f1  <= side_r[LEN_W-1].dneg;
		k_f1     <= side_r[LEN_W-1].k;
		degen_f1 <= (len_c == '0);
		for (int i = 0; i < 3; i++) begin
			num_f1[i] <= {side_r[LEN_W-1].dmag[i], {FRAC_BITS{1'b0}}};
		end
	end

	// unit components
	logic [2:0][QUO_W-1:0] quo_c;

	for (genvar g = 0; g < 3; g++) begin : g_div
		spf_div u_div (
			.clk (clk),
			.num (num_f1[g]),
			.den (len_f1),
			.quo (quo_c[g])
		);
	end

	// scalar force: k times stretch, then clip
	logic              vld_p;
	logic [PROD_W-1:0] prod_p;
	div_side_t         side_p;
	logic [HI_W-1:0]   hi_c;
	div_side_t         side_c;

	assign hi_c = prod_p[PROD_W-1:FRAC_BITS];

	always_comb begin
		side_c      = side_p;
		side_c.fmag = (hi_c > HI_W'(F_CLIP)) ? F_CLIP : FMAG_W'(hi_c);
	end

	logic      vld_d [0:DLY_N];
	div_side_t side_d [0:DLY_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= 1'b0;
			for (int n = 0; n <= DLY_N; n++) begin
				vld_d[n] <= 1'b0;
			end
		end else begin
			vld_p    <= vld_f1;
			vld_d[0] <= vld_p;
			for (int n = 1; n <= DLY_N; n++) begin
				vld_d[n] <= vld_d[n-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_p       <= PROD_W'(k_f1) * PROD_W'(smag_f1);
		side_p.fmag  <= '0;
		side_p.fneg  <= fneg_f1;
		side_p.dneg  <= dneg_f1;
		side_p.len   <= len_f1;
		side_p.degen <= degen_f1;
		side_d[0]    <= side_c;
		for (int n = 1; n <= DLY_N; n++) begin
			side_d[n] <= side_d[n-1];
		end
	end

	// force magnitude per axis
	logic                  vld_m;
	div_side_t             side_m;
	logic [2:0][MAG_W-1:0] mag_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m <= 1'b0;
		end else begin
			vld_m <= vld_d[DLY_N];
		end
	end

	always_ff @(posedge clk) begin
		side_m <= side_d[DLY_N];
		for (int i = 0; i < 3; i++) begin
			mag_m[i] <= MAG_W'(side_d[DLY_N].fmag) * MAG_W'(quo_c[i]);
		end
	end

	// sign, saturation and negation for B
	logic signed [2:0][COORD_WIDTH-1:0] fa_c;
	logic signed [2:0][COORD_WIDTH-1:0] fb_c;

	always_comb begin
		logic [MAG_W-FRAC_BITS-1:0] m;
		logic                       neg;
		for (int i = 0; i < 3; i++) begin
			m   = mag_m[i][MAG_W-1:FRAC_BITS];
			neg = (side_m.fneg != side_m.dneg[i]) && (m != '0);
			if (neg) begin
				if (m >= ((MAG_W - FRAC_BITS)'(1) << (COORD_WIDTH - 1))) begin
					fa_c[i] = FORCE_MIN;
				end else begin
					fa_c[i] = COORD_WIDTH'(0) - m[COORD_WIDTH-1:0];
				end
			end else begin
				if (m > (MAG_W - FRAC_BITS)'(FORCE_MAX)) begin
					fa_c[i] = FORCE_MAX;
				end else begin
					fa_c[i] = m[COORD_WIDTH-1:0];
				end
			end
			fb_c[i] = (fa_c[i] == FORCE_MIN) ? FORCE_MAX : -fa_c[i];
			if (side_m.degen) begin
				fa_c[i] = '0;
				fb_c[i] = '0;
			end
		end
	end

	// result registers
	logic                               done_q;
	logic signed [2:0][COORD_WIDTH-1:0] fa_q;
	logic signed [2:0][COORD_WIDTH-1:0] fb_q;
	logic [SPAN_W-1:0]                  span_q;
	logic                               degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_m;
		end
	end

	always_ff @(posedge clk) begin
		fa_q    <= fa_c;
		fb_q    <= fb_c;
		span_q  <= SPAN_W'(side_m.len);
		degen_q <= side_m.degen;
	end

	assign done        = done_q;
	assign force_a_x   = fa_q[0];
	assign force_a_y   = fa_q[1];
	assign force_a_z   = fa_q[2];
	assign force_b_x   = fb_q[0];
	assign force_b_y   = fb_q[1];
	assign force_b_z   = fb_q[2];
	assign span_length = span_q;
	assign degenerate  = degen_q;

	// coincident points give an all-zero result
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> force_a_x == '0 && force_a_y == '0 && force_a_z == '0
			&& force_b_x == '0 && force_b_y == '0 && force_b_z == '0 && span_length == '0)
		else $error("degenerate item with nonzero result");

	// a nonzero span is never flagged degenerate
	a_span_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (degenerate == (span_length == '0)))
		else $error("degenerate flag disagrees with span length");

	// force on B mirrors force on A
	a_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (force_b_x == -force_a_x || (force_a_x == FORCE_MIN && force_b_x == FORCE_MAX))
			&& (force_b_y == -force_a_y || (force_a_y == FORCE_MIN && force_b_y == FORCE_MAX))
			&& (force_b_z == -force_a_z || (force_a_z == FORCE_MIN && force_b_z == FORCE_MAX)))
		else $error("force on B is not the negation of force on A");

	// every valid item leaving the force magnitude stage raises the result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_m |=> done)
		else $error("result strobe lost");

endmodule
